@@ hw/rtl/hnai_pkg.sv @@
// hnai_pkg: shared types and constants of the hashed name absence index
// no dependencies
`default_nettype none
package hnai_pkg;
   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

   typedef enum logic [2:0] {
      MODE_LIST  = 3'd0,
      MODE_DONE  = 3'd1,
      MODE_ERROR = 3'd2,
      MODE_QUERY = 3'd3,
      MODE_CLEAR = 3'd4
   } mode_type;

   localparam logic [2:0] VERDICT_PRESENT  = 3'd0;
   localparam logic [2:0] VERDICT_ABSENT   = 3'd1;
   localparam logic [2:0] VERDICT_FALLBACK = 3'd2;
   localparam logic [2:0] VERDICT_COMPLETE = 3'd3;
   localparam logic [2:0] VERDICT_FAILED   = 3'd4;

   // index status
   localparam logic [1:0] STATUS_OPEN      = 2'd0;
   localparam logic [1:0] STATUS_COMPLETE  = 2'd1;
   localparam logic [1:0] STATUS_UNCERTAIN = 2'd2;

   // commands from front to back
   typedef enum logic [2:0] {
      CMD_STORE = 3'd0,
      CMD_QUERY = 3'd1,
      CMD_DONE  = 3'd2,
      CMD_ERROR = 3'd3,
      CMD_CLEAR = 3'd4,
      CMD_FAIL  = 3'd5,
      CMD_SKIP  = 3'd6,
      CMD_FALLB = 3'd7
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [63:0] hash;
   } job_type;
endpackage
`default_nettype wire

@@ hw/rtl/hashed_name_absence_index_top.sv @@
// hashed_name_absence_index_top: name listing and absence query index
// depends on hnai_pkg, hnai_front, hnai_queue, hnai_back
//
//  channel | direction | ports
//  req     | in        | req_push, req_full, req_mode, req_name_char, req_name_last
//  rsp     | out       | rsp_pop, rsp_empty, rsp_verdict, rsp_stored_entries
//
// one character word per cycle through the hasher; a name end goes to a four deep job queue
// a query searches the sorted store in binary steps, each a read state and a compare state
// the completion marker sorts the store in place by insertion: a read, a compare and a move
// state per entry, with a further move state for each shifted entry
// synchronous reset empties the index; no clearing pass, entries are written before read
// the front stalls only when the job queue is full; the back stalls while a word waits
`default_nettype none
module hashed_name_absence_index_top
   import hnai_pkg::*;
#(
   parameter int MAX_ENTRIES  = 1024,
   parameter int MAX_NAME_LEN = 255
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [2:0]  req_mode,
   input  wire logic [7:0]  req_name_char,
   input  wire logic        req_name_last,
   input  wire logic        rsp_pop,
   output logic             rsp_empty,
   output logic [2:0]       rsp_verdict,
   output logic [10:0]      rsp_stored_entries
);
   logic    f_valid, q_ready, in_ready, b_valid, b_take, o_valid;
   job_type f_job, b_job;

   // front: check and hash each character word
   hnai_front #(.MAX_NAME_LEN(MAX_NAME_LEN)) u_front (
      .clock, .reset, .in_valid(req_push), .in_mode(req_mode),
      .in_char(req_name_char), .in_last(req_name_last),
      .job_valid(f_valid), .job(f_job), .job_ready(q_ready), .in_ready(in_ready)
   );
   assign req_full = !in_ready;

   // decoupling queue
   hnai_queue u_queue (
      .clock, .reset, .wr_valid(f_valid), .wr_job(f_job), .wr_ready(q_ready),
      .rd_valid(b_valid), .rd_job(b_job), .rd_take(b_take)
   );

   // back: store, sort and search
   hnai_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
      .clock, .reset, .job_valid(b_valid), .job(b_job), .job_take(b_take),
      .out_valid(o_valid), .out_verdict(rsp_verdict),
      .out_entries(rsp_stored_entries), .out_pop(rsp_pop)
   );
   assign rsp_empty = !o_valid;
endmodule
`default_nettype wire

@@ hw/rtl/hnai_front.sv @@
// hnai_front: character checker and fnv-1a hasher, emits one job per name end or marker
// depends on hnai_pkg
`default_nettype none
module hnai_front
   import hnai_pkg::*;
#(
   parameter int MAX_NAME_LEN = 255
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire logic [2:0]  in_mode,
   input  wire logic [7:0]  in_char,
   input  wire logic        in_last,
   output logic             job_valid,
   output job_type          job,
   input  wire logic        job_ready,
   output logic             in_ready
);
   logic [63:0] hash_ff, hash_in;
   logic [8:0]  len_ff, len_in;
   logic        valid_ff, valid_in, dots_ff, dots_in;
   logic [63:0] mul;
   logic [7:0]  low;
   logic        allowed, ok, dotname, is_char;
   logic [8:0]  nlen;

   assign in_ready = job_ready;
   assign is_char = in_mode == MODE_LIST || in_mode == MODE_QUERY;
   assign allowed = (in_char >= 8'h61 && in_char <= 8'h7A) ||
                    (in_char >= 8'h41 && in_char <= 8'h5A) ||
                    (in_char >= 8'h30 && in_char <= 8'h39) ||
                    in_char == 8'h5F || in_char == 8'h2D || in_char == 8'h2E;
   assign low = (in_char >= 8'h41 && in_char <= 8'h5A) ? in_char + 8'd32 : in_char;
   // prime is sparse (bits 40, 8, 7, 5, 4, 1, 0), so the product is shifts and adds
   always_comb begin
      logic [63:0] x;
      x = hash_ff ^ {56'd0, low};
      mul = x + (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1);
   end
   assign nlen = (len_ff <= 9'(MAX_NAME_LEN)) ? len_ff + 9'd1 : len_ff;
   // the arriving character is the last one of the name
   assign ok = valid_ff && allowed && nlen >= 9'd1 && nlen <= 9'(MAX_NAME_LEN)
               && in_char != 8'h2E;
   assign dotname = dots_ff && in_char == 8'h2E && (nlen == 9'd1 || nlen == 9'd2);

   always_comb begin
      hash_in = hash_ff; len_in = len_ff; valid_in = valid_ff;
      dots_in = dots_ff;
      job_valid = 1'b0; job.cmd = CMD_SKIP; job.hash = mul;
      if (in_valid && job_ready) begin
         if (is_char) begin
            hash_in = mul; len_in = nlen; valid_in = valid_ff && allowed;
            dots_in = dots_ff && in_char == 8'h2E;
            if (in_last) begin
               hash_in = FNV_BASIS; len_in = '0; valid_in = 1'b1;
               dots_in = 1'b1;
               job_valid = 1'b1;
               if (in_mode == MODE_LIST)
                  job.cmd = dotname ? CMD_SKIP : (ok ? CMD_STORE : CMD_FAIL);
               else
                  job.cmd = ok ? CMD_QUERY : CMD_FALLB;
            end
         end else begin
            unique case (in_mode)
               MODE_DONE:  begin job_valid = 1'b1; job.cmd = CMD_DONE; end
               MODE_ERROR: begin job_valid = 1'b1; job.cmd = CMD_ERROR; end
               MODE_CLEAR: begin
                  job_valid = 1'b1; job.cmd = CMD_CLEAR;
                  hash_in = FNV_BASIS; len_in = '0; valid_in = 1'b1;
                  dots_in = 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS; len_ff <= '0; valid_ff <= 1'b1;
         dots_ff <= 1'b1;
      end else begin
         hash_ff <= hash_in; len_ff <= len_in; valid_ff <= valid_in;
         dots_ff <= dots_in;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/hnai_queue.sv @@
// hnai_queue: small job fifo between front and back
// depends on hnai_pkg
`default_nettype none
module hnai_queue
   import hnai_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic wr_valid,
   input  job_type   wr_job,
   output logic      wr_ready,
   output logic      rd_valid,
   output job_type   rd_job,
   input  wire logic rd_take
);
   job_type     slot_ff [4];
   logic [1:0]  wp_ff, rp_ff;
   logic [2:0]  cnt_ff;
   logic        do_wr, do_rd;

   assign wr_ready = cnt_ff != 3'd4;
   assign rd_valid = cnt_ff != 3'd0;
   assign rd_job = slot_ff[rp_ff];
   assign do_wr = wr_valid && wr_ready;
   assign do_rd = rd_take && rd_valid;

   always_ff @(posedge clock) begin
      if (do_wr) slot_ff[wp_ff] <= wr_job;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (do_wr) wp_ff <= wp_ff + 2'd1;
         if (do_rd) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, do_wr} - {2'd0, do_rd};
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/hnai_back.sv @@
// hnai_back: hash store, insertion sort on completion, binary search on query
// depends on hnai_pkg
`default_nettype none
module hnai_back
   import hnai_pkg::*;
#(
   parameter int MAX_ENTRIES = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        job_valid,
   input  job_type          job,
   output logic             job_take,
   output logic             out_valid,
   output logic [2:0]       out_verdict,
   output logic [10:0]      out_entries,
   input  wire logic        out_pop
);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = AW + 1;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SRD   = 7'b0000010,
      ST_SCMP  = 7'b0000100,
      ST_SMOVE = 7'b0001000,
      ST_QRD   = 7'b0010000,
      ST_QCMP  = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   logic [63:0] mem [MAX_ENTRIES];
   logic [63:0] rdata_ff, key_ff, key_in;
   logic [AW-1:0] raddr, waddr;
   logic [63:0] wdata;
   logic        we;
   state_type   st_ff, st_in;
   logic [1:0]  status_ff, status_in;
   logic [CW-1:0] total_ff, total_in, i_ff, i_in, j_ff, j_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] mid;
   logic [2:0]  verd_ff, verd_in;
   logic        ov_ff, ov_in;

   assign mid = CW'((lo_ff + hi_ff) >> 1);
   assign out_valid = ov_ff;
   assign out_verdict = verd_ff;
   assign out_entries = 11'(total_ff);
   assign job_take = st_ff == ST_IDLE && !ov_ff && job_valid;

   always_comb begin
      st_in = st_ff; status_in = status_ff; total_in = total_ff;
      i_in = i_ff; j_in = j_ff; lo_in = lo_ff; hi_in = hi_ff;
      key_in = key_ff; verd_in = verd_ff; ov_in = ov_ff;
      raddr = '0; waddr = total_ff[AW-1:0]; wdata = job.hash; we = 1'b0;
      if (ov_ff && out_pop) ov_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: if (job_take) begin
            case (job.cmd)
               CMD_STORE: if (status_ff == STATUS_OPEN) begin
                  if (total_ff >= CW'(MAX_ENTRIES)) begin
                     total_in = '0; status_in = STATUS_UNCERTAIN;
                     verd_in = VERDICT_FAILED; ov_in = 1'b1;
                  end else begin
                     we = 1'b1; total_in = total_ff + CW'(1);
                  end
               end
               CMD_FAIL: if (status_ff == STATUS_OPEN) begin
                  total_in = '0; status_in = STATUS_UNCERTAIN;
                  verd_in = VERDICT_FAILED; ov_in = 1'b1;
               end
               CMD_QUERY: begin
                  if (status_ff != STATUS_COMPLETE) begin
                     verd_in = VERDICT_FALLBACK; ov_in = 1'b1;
                  end else begin
                     key_in = job.hash; lo_in = '0; hi_in = total_ff;
                     st_in = ST_QRD;
                  end
               end
               CMD_FALLB: begin verd_in = VERDICT_FALLBACK; ov_in = 1'b1; end
               CMD_DONE: begin
                  if (status_ff == STATUS_OPEN) begin
                     status_in = STATUS_COMPLETE; i_in = CW'(1);
                     st_in = ST_SRD; verd_in = VERDICT_COMPLETE;
                  end else begin
                     verd_in = status_ff == STATUS_COMPLETE ? VERDICT_COMPLETE
                                                            : VERDICT_FAILED;
                     ov_in = 1'b1;
                  end
               end
               CMD_ERROR: begin
                  if (status_ff == STATUS_COMPLETE) verd_in = VERDICT_COMPLETE;
                  else begin
                     verd_in = VERDICT_FAILED; status_in = STATUS_UNCERTAIN;
                     total_in = '0;
                  end
                  ov_in = 1'b1;
               end
               CMD_CLEAR: begin status_in = STATUS_OPEN; total_in = '0; end
               default: ;
            endcase
         end
         // insertion sort: key = mem[i], shift larger entries up
         ST_SRD: begin
            if (i_ff >= total_ff) begin
               st_in = ST_OUT;
            end else begin
               raddr = i_ff[AW-1:0]; j_in = i_ff; st_in = ST_SCMP;
            end
         end
         ST_SCMP: begin
            // rdata holds mem[i], the key of this pass
            key_in = rdata_ff; raddr = AW'(j_ff - CW'(1)); st_in = ST_SMOVE;
         end
         ST_SMOVE: begin
            // rdata holds mem[j-1]; at j zero the key lands in slot 0
            if (j_ff != '0 && rdata_ff > key_ff) begin
               we = 1'b1; waddr = j_ff[AW-1:0]; wdata = rdata_ff;
               j_in = j_ff - CW'(1);
               if (j_ff != CW'(1)) raddr = AW'(j_ff - CW'(2));
               st_in = ST_SMOVE;
            end else begin
               we = 1'b1; waddr = j_ff[AW-1:0]; wdata = key_ff;
               i_in = i_ff + CW'(1); st_in = ST_SRD;
            end
         end
         ST_QRD: begin
            if (lo_ff >= hi_ff) begin
               verd_in = VERDICT_ABSENT; ov_in = 1'b1; st_in = ST_IDLE;
            end else begin
               raddr = mid[AW-1:0]; st_in = ST_QCMP;
            end
         end
         ST_QCMP: begin
            if (rdata_ff == key_ff) begin
               verd_in = VERDICT_PRESENT; ov_in = 1'b1; st_in = ST_IDLE;
            end else begin
               if (rdata_ff < key_ff) lo_in = mid + CW'(1);
               else hi_in = mid;
               st_in = ST_QRD;
            end
         end
         ST_OUT: begin ov_in = 1'b1; st_in = ST_IDLE; end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in; i_ff <= i_in; j_ff <= j_in;
      lo_ff <= lo_in; hi_ff <= hi_in; verd_ff <= verd_in;
      if (reset) begin
         st_ff <= ST_IDLE; status_ff <= STATUS_OPEN; total_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; status_ff <= status_in; total_ff <= total_in; ov_ff <= ov_in;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/hnai_checker.sv @@
// hnai_checker: port level checks of the index
// depends on hnai_pkg and hashed_name_absence_index_top
`default_nettype none
module hnai_checker
   import hnai_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_pop,
   input wire logic        rsp_empty,
   input wire logic [2:0]  rsp_verdict,
   input wire logic [10:0] rsp_stored_entries
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_verdict))
      else $error("waiting word changed");
   a_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_verdict <= VERDICT_FAILED)
      else $error("verdict out of range");
   a_fail: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_verdict == VERDICT_FAILED |-> rsp_stored_entries == 11'd0)
      else $error("failed index not empty");
endmodule
bind hashed_name_absence_index_top hnai_checker u_chk (.*);
`default_nettype wire

@@ test/tb_hashed_name_absence_index_top.sv @@
// tb_hashed_name_absence_index_top: self-checking bench for the name absence index
// drives character words through the push/full queue, predicts every verdict word
// depends on hnai_pkg and hashed_name_absence_index_top
`timescale 1ns / 100ps
module tb_hashed_name_absence_index_top;
   import hnai_pkg::*;

   localparam int MAX_ENTRIES  = 1024;
   localparam int MAX_NAME_LEN = 255;
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int ITEM_TARGET  = 1150;
   localparam int HOLD_CYCLES  = 400;
   localparam int SETTLE       = 2000;

   // index status as the predictor keeps it
   typedef enum logic [1:0] {IDX_OPEN, IDX_COMPLETE, IDX_UNCERTAIN} idx_status_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [10:0] entries;
   } verdict_word_type;

   // one row of the directed table: a word, plus a verdict typed in by hand where obvious
   typedef struct {
      logic [2:0]  mode;
      logic [7:0]  ch;
      bit          last;
      bit          typed;
      logic [2:0]  verdict;
      logic [10:0] entries;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [2:0]  req_mode;
   logic [7:0]  req_name_char;
   logic        req_name_last;
   logic        rsp_pop;
   logic        rsp_empty;
   logic [2:0]  rsp_verdict;
   logic [10:0] rsp_stored_entries;

   hashed_name_absence_index_top #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .MAX_NAME_LEN(MAX_NAME_LEN)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_name_char     (req_name_char),
      .req_name_last     (req_name_last),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_verdict       (rsp_verdict),
      .rsp_stored_entries(rsp_stored_entries)
   );

   // clock, period 2 ns
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // predictor state: index and the name under way
   // ---------------------------------------------------------------
   idx_status_type   idx_status;
   logic [63:0]      listed_hashes[$];
   logic [63:0]      name_fnv;
   int               name_len;
   bit               name_clean;
   logic [7:0]       name_prev;
   bit               name_all_dots;

   verdict_word_type pending_verdicts[$];

   int  words_sent;
   int  verdicts_seen;
   int  mismatches;
   int  cycle_count;
   int  idle_pct;
   int  stall_pct;
   bit  hold_request;
   int  hold_left;

   const string NAME_CHARS =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-.";

   function automatic bit char_ok(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == "_" || c == "-" || c == ".";
   endfunction

   function automatic void name_reset();
      name_fnv      = FNV_BASIS;
      name_len      = 0;
      name_clean    = 1'b1;
      name_prev     = 8'd0;
      name_all_dots = 1'b1;
   endfunction

   function automatic void index_empty(idx_status_type s);
      listed_hashes.delete();
      idx_status = s;
   endfunction

   // folds one character into the name and returns the verdict word it causes, if any
   function automatic bit predict_verdict(logic [2:0] mode, logic [7:0] c, bit last,
                                          output verdict_word_type w);
      logic [7:0] folded;
      bit         ok;
      bit         dots;
      bit         found;
      w = '0;
      if (mode == MODE_LIST || mode == MODE_QUERY) begin
         if (!char_ok(c)) name_clean = 1'b0;
         if (c != ".") name_all_dots = 1'b0;
         if (name_len <= MAX_NAME_LEN) name_len++;
         name_prev = c;
         folded = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
         name_fnv = (name_fnv ^ {56'd0, folded}) * FNV_PRIME;
         if (!last) return 1'b0;
         ok   = name_clean && name_len >= 1 && name_len <= MAX_NAME_LEN && name_prev != ".";
         dots = name_all_dots && (name_len == 1 || name_len == 2);
         if (mode == MODE_LIST) begin
            if (idx_status != IDX_OPEN || dots) begin
               name_reset();
               return 1'b0;
            end
            if (!ok || listed_hashes.size() >= MAX_ENTRIES) begin
               name_reset();
               index_empty(IDX_UNCERTAIN);
               w.verdict = VERDICT_FAILED;
               return 1'b1;
            end
            listed_hashes.push_back(name_fnv);
            name_reset();
            return 1'b0;
         end
         if (!ok || idx_status != IDX_COMPLETE) begin
            w.verdict = VERDICT_FALLBACK;
         end else begin
            found = 1'b0;
            foreach (listed_hashes[i]) if (listed_hashes[i] == name_fnv) found = 1'b1;
            w.verdict = found ? VERDICT_PRESENT : VERDICT_ABSENT;
         end
         name_reset();
         w.entries = 11'(listed_hashes.size());
         return 1'b1;
      end
      if (mode == MODE_DONE) begin
         if (idx_status == IDX_OPEN) idx_status = IDX_COMPLETE;
         w.verdict = (idx_status == IDX_COMPLETE) ? VERDICT_COMPLETE : VERDICT_FAILED;
         w.entries = 11'(listed_hashes.size());
         return 1'b1;
      end
      if (mode == MODE_ERROR) begin
         if (idx_status != IDX_COMPLETE) index_empty(IDX_UNCERTAIN);
         w.verdict = (idx_status == IDX_COMPLETE) ? VERDICT_COMPLETE : VERDICT_FAILED;
         w.entries = 11'(listed_hashes.size());
         return 1'b1;
      end
      if (mode == MODE_CLEAR) begin
         index_empty(IDX_OPEN);
         name_reset();
      end
      // modes 5 to 7 leave everything alone
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------
   // sender: one word per call, held until the block takes it
   // ---------------------------------------------------------------
   task automatic push_word(logic [2:0] mode, logic [7:0] c, bit last,
                            bit typed = 1'b0, logic [2:0] tv = '0, logic [10:0] tn = '0);
      verdict_word_type w;
      if ($urandom_range(99) < idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_mode      <= mode;
      req_name_char <= c;
      req_name_last <= last;
      // full is read before the edge updates land, so this is the accepting edge
      do @(posedge clock); while (req_full);
      words_sent++;
      if (predict_verdict(mode, c, last, w)) begin
         if (typed) begin
            w.verdict = tv;
            w.entries = tn;
         end
         pending_verdicts.push_back(w);
      end
   endtask

   task automatic push_name(logic [2:0] mode, string s);
      for (int i = 0; i < s.len(); i++) push_word(mode, s[i], i == s.len() - 1);
   endtask

   task automatic go_quiet();
      req_push <= 1'b0;
      @(posedge clock);
   endtask

   // waits for every verdict word owed, then lets the back end finish any silent work
   task automatic drain(int extra);
      go_quiet();
      wait (pending_verdicts.size() == 0);
      repeat (extra) @(posedge clock);
   endtask

   function automatic string random_name(int max_len);
      string s;
      int    n;
      n = $urandom_range(1, max_len);
      s = "";
      for (int i = 0; i < n; i++) begin
         s = {s, NAME_CHARS.substr(0, 0)};
         s[i] = NAME_CHARS[$urandom_range(NAME_CHARS.len() - 1)];
      end
      // names ending in a dot would fail the listing, keep them rare
      if (s[n-1] == "." && $urandom_range(99) < 95) s[n-1] = "x";
      return s;
   endfunction

   // same name with letter case flipped here and there, hashes identically
   function automatic string case_mixed(string s);
      string r;
      r = s;
      for (int i = 0; i < r.len(); i++)
         if ($urandom_range(1) && r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 8'd32;
         else if ($urandom_range(1) && r[i] >= "A" && r[i] <= "Z") r[i] = r[i] + 8'd32;
      return r;
   endfunction

   function automatic string noise_name();
      string s;
      s = random_name(8);
      s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
      return s;
   endfunction

   // ---------------------------------------------------------------
   // receiver and checker
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      verdict_word_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected verdict word: verdict %0d entries %0d",
                           rsp_verdict, rsp_stored_entries);
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_verdict !== want.verdict || rsp_stored_entries !== want.entries) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("verdict word %0d: expected verdict %0d entries %0d, got %0d %0d",
                              verdicts_seen, want.verdict, want.entries,
                              rsp_verdict, rsp_stored_entries);
               end
            end
         end
         // long hold-off runs in its own count so the sender keeps pushing
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_pop   <= 1'b0;
         end else if (hold_request) begin
            hold_request <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            rsp_pop      <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdict words owed",
                  cycle_count, pending_verdicts.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // directed table: opening run over the special cases
   // ---------------------------------------------------------------
   row_type opening[] = '{
      // query before any listing falls back
      '{MODE_QUERY, "a", 1, 1, VERDICT_FALLBACK, 11'd0},
      '{MODE_LIST,  "A", 1, 0, 0, 0},
      '{MODE_LIST,  "b", 0, 0, 0, 0},
      '{MODE_LIST,  "c", 1, 0, 0, 0},
      // dot and dot-dot are skipped
      '{MODE_LIST,  ".", 1, 0, 0, 0},
      '{MODE_LIST,  ".", 0, 0, 0, 0},
      '{MODE_LIST,  ".", 1, 0, 0, 0},
      // undefined modes are ignored
      '{3'd5, 8'hFF, 1, 0, 0, 0},
      '{3'd7, 8'h00, 0, 0, 0, 0},
      '{MODE_DONE,  "z", 1, 1, VERDICT_COMPLETE, 11'd2},
      // upper case folds to lower case
      '{MODE_QUERY, "a", 1, 0, 0, 0},
      '{MODE_QUERY, "B", 0, 0, 0, 0},
      '{MODE_QUERY, "c", 1, 0, 0, 0},
      '{MODE_QUERY, "x", 1, 0, 0, 0},
      // trailing dot and zero character fall back
      '{MODE_QUERY, ".", 1, 1, VERDICT_FALLBACK, 11'd2},
      '{MODE_QUERY, 8'h00, 1, 1, VERDICT_FALLBACK, 11'd2},
      '{MODE_ERROR, 8'hFF, 1, 1, VERDICT_COMPLETE, 11'd2},
      '{MODE_LIST,  "q", 1, 0, 0, 0},
      '{MODE_CLEAR, 8'h00, 0, 0, 0, 0},
      '{MODE_LIST,  8'hFF, 1, 1, VERDICT_FAILED, 11'd0},
      '{MODE_DONE,  8'h00, 0, 1, VERDICT_FAILED, 11'd0},
      '{MODE_ERROR, 8'h00, 0, 1, VERDICT_FAILED, 11'd0},
      '{MODE_CLEAR, 8'h00, 0, 0, 0, 0},
      // clear in the middle of a name discards it; mixed modes share one name
      '{MODE_LIST,  "k", 0, 0, 0, 0},
      '{MODE_CLEAR, 8'h00, 0, 0, 0, 0}
   };

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin
      string names[$];
      string s;
      int    episode;
      int    n;
      reset         <= 1'b1;
      req_push      <= 1'b0;
      req_mode      <= '0;
      req_name_char <= '0;
      req_name_last <= 1'b0;
      rsp_pop       <= 1'b0;
      idle_pct      = 0;
      stall_pct     = 0;
      hold_request  = 1'b0;
      hold_left     = 0;
      cycle_count   = 0;
      words_sent    = 0;
      verdicts_seen = 0;
      mismatches    = 0;
      idx_status    = IDX_OPEN;
      listed_hashes.delete();
      name_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i])
         push_word(opening[i].mode, opening[i].ch, opening[i].last, opening[i].typed,
                   opening[i].verdict, opening[i].entries);
      push_word(MODE_QUERY, "m", 0);
      push_word(MODE_LIST, "n", 1);
      push_word(MODE_DONE, 8'h00, 0, 1, VERDICT_COMPLETE, 11'd1);
      push_name(MODE_QUERY, "mn");

      // longest legal name is listed, one more character falls back
      push_word(MODE_CLEAR, 8'h00, 0);
      s = random_name(1);
      for (int i = 1; i < MAX_NAME_LEN; i++) s = {s, "q"};
      push_name(MODE_LIST, s);
      push_word(MODE_DONE, 8'h00, 0);
      push_name(MODE_QUERY, {s, "q"});
      drain(50);

      // random episodes: clear, list, complete, query
      episode = 0;
      while (words_sent < ITEM_TARGET || episode < 6) begin
         case (episode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 45; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 45; end
            default: begin idle_pct = 12; stall_pct = 12; end
         endcase
         push_word(MODE_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
         names.delete();
         n = ($urandom_range(9) == 0) ? 40 : $urandom_range(0, 16);
         for (int i = 0; i < n; i++) begin
            s = random_name(10);
            names.push_back(s);
            push_name(MODE_LIST, s);
            // occasional noise: bad names, error marker, undefined modes, bad queries
            case ($urandom_range(59))
               0: push_name(MODE_LIST, noise_name());
               1: push_word(MODE_ERROR, 8'($urandom_range(255)), 1'($urandom_range(1)));
               2: push_word(3'($urandom_range(5, 7)), 8'($urandom_range(255)),
                            1'($urandom_range(1)));
               3: push_name(MODE_QUERY, noise_name());
               default: ;
            endcase
         end
         if ($urandom_range(9) != 0)
            push_word(MODE_DONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
         if (episode == 3) hold_request = 1'b1;
         for (int i = 0; i < 8; i++) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4:
                  if (names.size() > 0) push_name(MODE_QUERY,
                                                  case_mixed(names[$urandom_range(names.size()-1)]));
                  else push_name(MODE_QUERY, random_name(6));
               5: push_name(MODE_QUERY, noise_name());
               6: push_name(MODE_LIST, random_name(4));
               default: push_name(MODE_QUERY, random_name(6));
            endcase
         end
         if ($urandom_range(7) == 0)
            push_word(MODE_ERROR, 8'($urandom_range(255)), 1'($urandom_range(1)));
         // in episode five, pause until every owed verdict word is back
         if (episode == 5) drain(100);
         episode++;
      end

      drain(SETTLE);
      $display("%0d words pushed over %0d random episodes, %0d verdict words checked",
               words_sent, episode, verdicts_seen);
      $display("covered skipped dot names, case folding, longest and overlong names, bad names");
      if (mismatches == 0 && pending_verdicts.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
